>>> design/svf_pkg.sv
// Shared constants and types for the state variable highpass filter.
package svf_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int STATE_BITS    = 40;
    localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int COEF_BITS     = 32;
    localparam int PROD_BITS     = 2 * COEF_BITS;
    localparam int ROUND_BITS    = PROD_BITS + 1;
    localparam int SH_GAIN       = 28;
    localparam int SH_NORM       = 30;
    localparam int LO_BITS       = ROUND_BITS - SH_GAIN;
    localparam int R_BITS        = STATE_BITS + 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int GAIN_BITS     = 32;
    localparam int DAMP_BITS     = 30;
    localparam int NORM_BITS     = 31;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(17594000);
    localparam logic [DAMP_BITS-1:0] DAMP_RESET = DAMP_BITS'(379625062);
    localparam logic [NORM_BITS-1:0] NORM_RESET = NORM_BITS'(978807000);

    typedef logic signed [STATE_BITS-1:0] state_t;
    typedef logic [COEF_BITS-1:0]         coef_t;

    localparam state_t STATE_MAX = state_t'({1'b0, {(STATE_BITS-1){1'b1}}});
    localparam state_t STATE_MIN = ~STATE_MAX;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CUTOFF_GAIN = 2'd0,
        CFG_DAMPING     = 2'd1,
        CFG_NORM_FACTOR = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        coef_t gain;
        coef_t damp;
        coef_t norm;
    } coef_set_t;

    typedef struct packed {
        logic   start;
        logic   sh30;
        state_t a;
        coef_t  c;
    } mul_req_t;

    typedef struct packed {
        logic   done;
        state_t value;
    } mul_rsp_t;

endpackage

>>> design/svf_cfg_regs.sv
// Coefficient register bank written through the configuration channel.
module svf_cfg_regs
    import svf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output coef_set_t                coefs
);

    logic [GAIN_BITS-1:0] gain_reg;
    logic [DAMP_BITS-1:0] damp_reg;
    logic [NORM_BITS-1:0] norm_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            damp_reg <= DAMP_RESET;
            norm_reg <= NORM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CUTOFF_GAIN: gain_reg <= cfg_data[GAIN_BITS-1:0];
                CFG_DAMPING:     damp_reg <= cfg_data[DAMP_BITS-1:0];
                CFG_NORM_FACTOR: norm_reg <= cfg_data[NORM_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign coefs.gain = COEF_BITS'(gain_reg);
    assign coefs.damp = COEF_BITS'(damp_reg);
    assign coefs.norm = COEF_BITS'(norm_reg);

endmodule

>>> design/svf_mul_unit.sv
// Multi-cycle rounded coefficient multiplier built on one 32x32 multiplier.
module svf_mul_unit
    import svf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} mstate_t;

    mstate_t               state_reg;
    logic                  neg_reg;
    logic                  sh30_reg;
    logic [STATE_BITS-1:0] mag_reg;
    coef_t                 c_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [LO_BITS-1:0]    lo_reg;
    state_t                result_reg;
    logic                  done_reg;

    logic [STATE_BITS-1:0] mag_in;
    logic [COEF_BITS-1:0]  mul_a;
    logic [PROD_BITS-1:0]  mul_p;
    logic [ROUND_BITS-1:0] rounded;
    logic [LO_BITS-1:0]    lo_next;
    logic [R_BITS-1:0]     hi_part;
    logic [R_BITS-1:0]     mag_sum;
    logic [R_BITS-1:0]     limit;
    state_t                trunc;
    state_t                result_next;

    assign mag_in = req.a[STATE_BITS-1] ? (~req.a + 1'b1) : req.a;

    assign mul_a = (state_reg == M_HI) ? COEF_BITS'(mag_reg >> COEF_BITS)
                                       : mag_reg[COEF_BITS-1:0];
    assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(c_reg);

    always_comb
    begin
        rounded = ROUND_BITS'(prod_reg) + (sh30_reg ? (ROUND_BITS'(1) << (SH_NORM - 1))
                                                    : (ROUND_BITS'(1) << (SH_GAIN - 1)));
        lo_next = sh30_reg ? LO_BITS'(rounded >> SH_NORM) : LO_BITS'(rounded >> SH_GAIN);
        hi_part = R_BITS'(prod_reg[STATE_BITS-1:0]);
        hi_part = sh30_reg ? (hi_part << (COEF_BITS - SH_NORM))
                           : (hi_part << (COEF_BITS - SH_GAIN));
        mag_sum = hi_part + R_BITS'(lo_reg);
        limit   = R_BITS'(1) << (STATE_BITS - 1);
        if (!neg_reg)
            limit = limit - 1'b1;
        trunc = state_t'(mag_sum[STATE_BITS-1:0]);
        if (mag_sum > limit)
            result_next = neg_reg ? STATE_MIN : STATE_MAX;
        else
            result_next = neg_reg ? -trunc : trunc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            neg_reg    <= 1'b0;
            sh30_reg   <= 1'b0;
            mag_reg    <= '0;
            c_reg      <= '0;
            prod_reg   <= '0;
            lo_reg     <= '0;
            result_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg   <= req.a[STATE_BITS-1];
                        sh30_reg  <= req.sh30;
                        mag_reg   <= mag_in;
                        c_reg     <= req.c;
                        state_reg <= M_LO;
                    end
                end
                M_LO:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= M_HI;
                end
                M_HI:
                begin
                    lo_reg    <= lo_next;
                    prod_reg  <= mul_p;
                    state_reg <= M_FIN;
                end
                M_FIN:
                begin
                    result_reg <= result_next;
                    done_reg   <= 1'b1;
                    state_reg  <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = result_reg;

endmodule

>>> design/svf_core.sv
// Filter sequencer: integrator states, saturating adder, multiplier requests.
module svf_core
    import svf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  coef_set_t                     coefs,
    input  logic                          out_free,
    output logic                          busy,
    output logic                          hp_load,
    output logic [SAMPLE_BITS-1:0]        hp_sample,
    output mul_req_t                      mul_req,
    input  mul_rsp_t                      mul_rsp
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DAMP,
        ST_MUL_GS1,
        ST_SUM_FB,
        ST_SUB_X,
        ST_SUB_S2,
        ST_MUL_NORM,
        ST_MUL_V1,
        ST_ADD_BP,
        ST_ADD_S1,
        ST_MUL_V2,
        ST_ADD_LP,
        ST_ADD_S2,
        ST_OUT
    } step_t;

    localparam state_t SAMPLE_MAX = state_t'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam state_t SAMPLE_MIN = ~SAMPLE_MAX;

    step_t  step_reg;
    logic   wait_reg;
    state_t x_reg;
    state_t acc_reg;
    state_t hp_reg;
    state_t v_reg;
    state_t bp_reg;
    state_t s1_reg;
    state_t s2_reg;

    logic   is_mul;
    state_t add_a;
    state_t add_b;
    logic   add_sub;
    state_t add_y;
    state_t hp_sat;

    function automatic state_t sat_add(state_t a, state_t b, logic sub);
        logic signed [STATE_BITS:0] s;
        s = sub ? ((STATE_BITS+1)'(a) - (STATE_BITS+1)'(b))
                : ((STATE_BITS+1)'(a) + (STATE_BITS+1)'(b));
        if (s[STATE_BITS] != s[STATE_BITS-1])
            return s[STATE_BITS] ? STATE_MIN : STATE_MAX;
        return state_t'(s[STATE_BITS-1:0]);
    endfunction

    always_comb
    begin
        is_mul       = 1'b0;
        mul_req.a    = s1_reg;
        mul_req.c    = coefs.gain;
        mul_req.sh30 = 1'b0;
        add_a        = acc_reg;
        add_b        = v_reg;
        add_sub      = 1'b0;
        unique case (step_reg)
            ST_MUL_DAMP:
            begin
                is_mul    = 1'b1;
                mul_req.c = coefs.damp;
            end
            ST_MUL_GS1:  is_mul = 1'b1;
            ST_MUL_NORM:
            begin
                is_mul       = 1'b1;
                mul_req.a    = acc_reg;
                mul_req.c    = coefs.norm;
                mul_req.sh30 = 1'b1;
            end
            ST_MUL_V1:
            begin
                is_mul    = 1'b1;
                mul_req.a = hp_reg;
            end
            ST_MUL_V2:
            begin
                is_mul    = 1'b1;
                mul_req.a = bp_reg;
            end
            ST_SUB_X:
            begin
                add_a   = x_reg;
                add_b   = acc_reg;
                add_sub = 1'b1;
            end
            ST_SUB_S2:
            begin
                add_b   = s2_reg;
                add_sub = 1'b1;
            end
            ST_ADD_BP:
            begin
                add_a = v_reg;
                add_b = s1_reg;
            end
            ST_ADD_S1:  add_a = bp_reg;
            ST_ADD_LP:
            begin
                add_a = v_reg;
                add_b = s2_reg;
            end
            default: ;
        endcase
        mul_req.start = is_mul && !wait_reg;
        add_y         = sat_add(add_a, add_b, add_sub);
    end

    always_comb
    begin
        if (hp_reg > SAMPLE_MAX)
            hp_sat = SAMPLE_MAX;
        else if (hp_reg < SAMPLE_MIN)
            hp_sat = SAMPLE_MIN;
        else
            hp_sat = hp_reg;
    end

    assign hp_sample = hp_sat[SAMPLE_BITS-1:0];
    assign hp_load   = (step_reg == ST_OUT) && out_free;
    assign busy      = (step_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
            wait_reg <= 1'b0;
            x_reg    <= '0;
            acc_reg  <= '0;
            hp_reg   <= '0;
            v_reg    <= '0;
            bp_reg   <= '0;
            s1_reg   <= '0;
            s2_reg   <= '0;
        end
        else
        begin
            if (is_mul)
            begin
                if (!wait_reg)
                    wait_reg <= 1'b1;
                else if (mul_rsp.done)
                    wait_reg <= 1'b0;
            end
            unique case (step_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        x_reg    <= state_t'(sample);
                        step_reg <= ST_MUL_DAMP;
                    end
                end
                ST_MUL_DAMP:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        acc_reg  <= mul_rsp.value;
                        step_reg <= ST_MUL_GS1;
                    end
                end
                ST_MUL_GS1:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        v_reg    <= mul_rsp.value;
                        step_reg <= ST_SUM_FB;
                    end
                end
                ST_SUM_FB:
                begin
                    acc_reg  <= add_y;
                    step_reg <= ST_SUB_X;
                end
                ST_SUB_X:
                begin
                    acc_reg  <= add_y;
                    step_reg <= ST_SUB_S2;
                end
                ST_SUB_S2:
                begin
                    acc_reg  <= add_y;
                    step_reg <= ST_MUL_NORM;
                end
                ST_MUL_NORM:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        hp_reg   <= mul_rsp.value;
                        step_reg <= ST_MUL_V1;
                    end
                end
                ST_MUL_V1:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        v_reg    <= mul_rsp.value;
                        step_reg <= ST_ADD_BP;
                    end
                end
                ST_ADD_BP:
                begin
                    bp_reg   <= add_y;
                    step_reg <= ST_ADD_S1;
                end
                ST_ADD_S1:
                begin
                    s1_reg   <= add_y;
                    step_reg <= ST_MUL_V2;
                end
                ST_MUL_V2:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        v_reg    <= mul_rsp.value;
                        step_reg <= ST_ADD_LP;
                    end
                end
                ST_ADD_LP:
                begin
                    acc_reg  <= add_y;
                    step_reg <= ST_ADD_S2;
                end
                ST_ADD_S2:
                begin
                    s2_reg   <= add_y;
                    step_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                        step_reg <= ST_IDLE;
                end
                default: step_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> design/svf_highpass_filter_unit.sv
// Top level of the fixed-point trapezoidal state variable highpass filter.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   s_axis_tdata: sample_in
//  m_axis    out  m_axis_tvalid/m_axis_tready   m_axis_tdata: highpass_out
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A sample keeps the block busy after its beat: five coefficient products through
// the shared 32x32 multiplier, seven saturating adder steps and one output load.
// A new sample is taken only once the block is idle again.
// Reset loads the default coefficients and clears both integrators.
// A stalled output holds the finished sample; the next sample then waits in its
// output load step, which keeps s_axis_tready low until the output beat is taken.
module svf_highpass_filter_unit
    import svf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDATA_BITS-1:0]    s_axis_tdata,   // sample_in
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDATA_BITS-1:0]    m_axis_tdata,   // highpass_out
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    coef_set_t              coefs;
    mul_req_t               mul_req;
    mul_rsp_t               mul_rsp;
    logic                   core_busy;
    logic                   hp_load;
    logic [SAMPLE_BITS-1:0] hp_sample;
    logic                   out_free;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    svf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    svf_mul_unit u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    svf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid && s_axis_tready),
        .sample    (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
        .coefs     (coefs),
        .out_free  (out_free),
        .busy      (core_busy),
        .hp_load   (hp_load),
        .hp_sample (hp_sample),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp)
    );

    assign s_axis_tready = !core_busy;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (hp_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (hp_load)
            out_data_reg <= hp_sample;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_BITS'(out_data_reg);

    // input beat starts a run that keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // a waiting output beat is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        !(hp_load && m_axis_tvalid && !m_axis_tready))
        else $error("output beat overwritten");

    // every finished product is preceded by its request
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> $past(mul_req.start, 4))
        else $error("multiplier done without request");

    // no new product requested while the multiplier is working
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |=> !mul_req.start)
        else $error("multiplier request while busy");

endmodule
